FILE: rtl/core/tbmc_pkg.sv
// shared types and constants for the twelve-bit execute core
package tbmc_pkg;

    localparam int WORD_W  = 12;
    localparam int ADDR_W  = 15;
    localparam int FIELD_W = 3;

    typedef enum logic [1:0] {
        OP_EXEC    = 2'd0,
        OP_DEPOSIT = 2'd1,
        OP_LOADPC  = 2'd2,
        OP_EXAMINE = 2'd3
    } op_t;

    localparam logic [2:0] FN_AND = 3'd0;
    localparam logic [2:0] FN_TAD = 3'd1;
    localparam logic [2:0] FN_ISZ = 3'd2;
    localparam logic [2:0] FN_DCA = 3'd3;
    localparam logic [2:0] FN_JMS = 3'd4;
    localparam logic [2:0] FN_JMP = 3'd5;
    localparam logic [2:0] FN_IOT = 3'd6;
    localparam logic [2:0] FN_OPR = 3'd7;

    localparam logic [2:0] MEX_DEV_HI = 3'o2;
    localparam logic [2:0] MEX_RDF    = 3'd1;
    localparam logic [2:0] MEX_RIF    = 3'd2;
    localparam logic [2:0] MEX_RIB    = 3'd3;
    localparam logic [2:0] MEX_READ   = 3'd4;

    typedef struct packed {
        logic [1:0]  op;
        logic [11:0] instruction;
        logic [14:0] address;
        logic [11:0] data;
    } in_item_t;

    typedef struct packed {
        logic [11:0] program_counter;
        logic [11:0] accumulator;
        logic        link;
        logic        halted;
        logic [14:0] effective_address;
        logic [2:0]  instruction_field;
        logic [2:0]  operand_field;
        logic        io_request;
        logic [5:0]  io_device;
        logic [2:0]  io_command;
        logic [11:0] memory_word;
    } out_item_t;

    typedef struct packed {
        logic [11:0] pc;
        logic [11:0] acc;
        logic        link;
        logic        halt;
    } cpu_regs_t;

    // group 1 and group 2 operate, one item
    function automatic cpu_regs_t operate(cpu_regs_t r, logic [11:0] ins, logic [11:0] sw);
        cpu_regs_t o;
        logic any;
        logic skip;
        logic [12:0] w;
        o = r;
        any = 1'b0;
        skip = 1'b0;
        w = '0;
        if (ins[8]) begin
            any = (ins[6] && r.acc[11]) || (ins[5] && r.acc == '0) || (ins[4] && r.link);
            skip = ins[3] ? !any : any;
            if (ins[7]) o.acc = '0;
            if (ins[2]) o.acc = o.acc | sw;
            if (ins[1]) o.halt = 1'b1;
            if (skip) o.pc = o.pc + 12'd1;
        end
        else begin
            if (ins[7]) o.acc = '0;
            if (ins[6]) o.link = 1'b0;
            if (ins[5]) o.acc = ~o.acc;
            if (ins[4]) o.link = ~o.link;
            if (ins[0]) begin
                if (o.acc == 12'o7777) o.link = ~o.link;
                o.acc = o.acc + 12'd1;
            end
            if (ins[3]) begin
                w = {o.link, o.acc};
                o.link = w[0]; o.acc = w[12:1];
                if (ins[1]) begin
                    w = {o.link, o.acc};
                    o.link = w[0]; o.acc = w[12:1];
                end
            end
            if (ins[2]) begin
                w = {o.acc, o.link};
                o.link = w[12]; o.acc = w[11:0];
                if (ins[1]) begin
                    w = {o.acc, o.link};
                    o.link = w[12]; o.acc = w[11:0];
                end
            end
        end
        o.pc = o.pc + 12'd1;
        return o;
    endfunction

endpackage

FILE: rtl/core/tbmc_stream_if.sv
// valid/ready channel interfaces for input and result items
interface tbmc_in_if;
    logic                valid;
    logic                ready;
    tbmc_pkg::in_item_t  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface tbmc_out_if;
    logic                valid;
    logic                ready;
    tbmc_pkg::out_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/tbmc_ram.sv
// generic single-port ram with registered read
module tbmc_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

FILE: rtl/core/twelve_bit_minicomputer_execute_core.sv
// execute core: sequencer around one banked core memory
// one item at a time; no new item is accepted while a result waits untaken
// the sequencer shares the single memory port among pointer read, auto-index write,
// operand read and write-back
// rst_n clears the state, cpu, field, switch and output-valid registers, but not the item,
// address, word and result registers; core memory content is undefined until written
module twelve_bit_minicomputer_execute_core #(
    parameter int MEMORY_FIELDS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [11:0] cfg_wdata,
    tbmc_in_if.sink     in_ch,
    tbmc_out_if.source  out_ch
);
    localparam int DEPTH = MEMORY_FIELDS * 4096;
    localparam int MA_W  = $clog2(DEPTH);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PTR   = 7'b0000010,
        S_PWAIT = 7'b0000100,
        S_OPRD  = 7'b0001000,
        S_OWAIT = 7'b0010000,
        S_DONE  = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    tbmc_pkg::in_item_t item_reg, item_next;
    tbmc_pkg::cpu_regs_t regs_reg, regs_next;
    logic [2:0] df_reg, df_next, if_reg, if_next, ib_reg, ib_next;
    logic [11:0] sw_reg;
    logic [14:0] ea_reg, ea_next;
    logic [11:0] word_reg, word_next;
    tbmc_pkg::out_item_t res_reg, res_next;
    logic out_valid_reg, out_valid_next;

    logic        mem_we;
    logic [14:0] mem_a15;
    logic [11:0] mem_wd, mem_rd;
    logic        mem_ok;

    tbmc_ram #(.WIDTH(12), .DEPTH(DEPTH)) u_core (
        .clk(clk), .we(mem_we && mem_ok), .addr(mem_a15[MA_W-1:0]),
        .wdata(mem_wd), .rdata(mem_rd)
    );

    // fields beyond the fitted memory read as zero and ignore writes
    logic        rd_ok_reg;
    logic [11:0] rdv;
    assign mem_ok = ({1'b0, mem_a15} < 16'(DEPTH));
    assign rdv    = rd_ok_reg ? mem_rd : 12'd0;

    logic [2:0]  fn;
    logic [11:0] pg_word;
    logic        autoidx;
    logic [11:0] ptr_inc;
    logic [12:0] sum;
    logic [11:0] isz_v;
    tbmc_pkg::cpu_regs_t opr_r;

    assign in_ch.ready = (state_reg == S_IDLE) && !(out_valid_reg && !out_ch.ready);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.payload = res_reg;

    always_comb
    begin
        fn      = item_reg.instruction[11:9];
        pg_word = {(item_reg.instruction[7] ? regs_reg.pc[11:7] : 5'd0),
                   item_reg.instruction[6:0]};
        autoidx = (pg_word[11:3] == 9'd1);
        ptr_inc = rdv + 12'd1;
        sum     = {1'b0, regs_reg.acc} + {1'b0, rdv};
        isz_v   = rdv + 12'd1;
        opr_r   = tbmc_pkg::operate(regs_reg, item_reg.instruction, sw_reg);

        state_next = state_reg;
        item_next = item_reg;
        regs_next = regs_reg;
        df_next = df_reg; if_next = if_reg; ib_next = ib_reg;
        ea_next = ea_reg; word_next = word_reg;
        res_next = res_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        mem_we = 1'b0; mem_a15 = ea_reg; mem_wd = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    item_next = in_ch.payload;
                    ea_next = '0;
                    res_next.memory_word = '0;
                    res_next.io_request = 1'b0;
                    res_next.io_device = '0;
                    res_next.io_command = '0;
                    state_next = S_PTR;
                end
            end
            S_PTR:
            begin
                state_next = S_DONE;
                case (item_reg.op)
                    tbmc_pkg::OP_DEPOSIT:
                    begin
                        mem_a15 = item_reg.address; mem_we = 1'b1;
                        mem_wd = item_reg.data; ea_next = item_reg.address;
                    end
                    tbmc_pkg::OP_LOADPC:
                    begin
                        regs_next.pc = item_reg.address[11:0];
                        regs_next.halt = 1'b0;
                        if_next = item_reg.address[14:12];
                        ib_next = item_reg.address[14:12];
                    end
                    tbmc_pkg::OP_EXAMINE:
                    begin
                        mem_a15 = item_reg.address; ea_next = item_reg.address;
                        state_next = S_OWAIT;
                    end
                    default:
                    begin
                        if (fn <= tbmc_pkg::FN_JMP)
                        begin
                            word_next = pg_word;
                            if (item_reg.instruction[8])
                            begin
                                mem_a15 = {if_reg, pg_word};
                                state_next = S_PWAIT;
                            end
                            else
                            begin
                                ea_next = {(fn >= tbmc_pkg::FN_JMS) ? ib_reg : if_reg, pg_word};
                                state_next = S_OPRD;
                            end
                        end
                        else if (fn == tbmc_pkg::FN_IOT)
                        begin
                            regs_next.pc = regs_reg.pc + 12'd1;
                            if (item_reg.instruction[8:6] == tbmc_pkg::MEX_DEV_HI)
                            begin
                                if (item_reg.instruction[2])
                                begin
                                    if (item_reg.instruction[2:0] == tbmc_pkg::MEX_READ)
                                    begin
                                        case (item_reg.instruction[5:3])
                                            tbmc_pkg::MEX_RDF: regs_next.acc =
                                                {regs_reg.acc[11:6], df_reg, regs_reg.acc[2:0]};
                                            tbmc_pkg::MEX_RIF: regs_next.acc =
                                                {regs_reg.acc[11:6], if_reg, regs_reg.acc[2:0]};
                                            tbmc_pkg::MEX_RIB: regs_next.acc =
                                                {regs_reg.acc[11:6], if_reg, df_reg};
                                            default: ;
                                        endcase
                                    end
                                end
                                else
                                begin
                                    if (item_reg.instruction[0]) df_next = item_reg.instruction[5:3];
                                    if (item_reg.instruction[1]) ib_next = item_reg.instruction[5:3];
                                end
                            end
                            else
                            begin
                                res_next.io_request = 1'b1;
                                res_next.io_device = item_reg.instruction[8:3];
                                res_next.io_command = item_reg.instruction[2:0];
                            end
                        end
                        else
                            regs_next = opr_r;
                    end
                endcase
            end
            S_PWAIT:
            begin
                // pointer data back; auto-index writes it incremented
                if (autoidx)
                begin
                    mem_a15 = {if_reg, word_reg}; mem_we = 1'b1; mem_wd = ptr_inc;
                    word_next = ptr_inc;
                    ea_next = {(fn >= tbmc_pkg::FN_JMS) ? ib_reg : df_reg, ptr_inc};
                end
                else
                begin
                    word_next = rdv;
                    ea_next = {(fn >= tbmc_pkg::FN_JMS) ? ib_reg : df_reg, rdv};
                end
                state_next = S_OPRD;
            end
            S_OPRD:
            begin
                mem_a15 = ea_reg;
                state_next = S_DONE;
                case (fn) inside
                    tbmc_pkg::FN_AND, tbmc_pkg::FN_TAD, tbmc_pkg::FN_ISZ:
                        state_next = S_OWAIT;
                    tbmc_pkg::FN_DCA:
                    begin
                        mem_we = 1'b1; mem_wd = regs_reg.acc;
                        regs_next.acc = '0; regs_next.pc = regs_reg.pc + 12'd1;
                    end
                    tbmc_pkg::FN_JMS:
                    begin
                        mem_we = 1'b1; mem_wd = regs_reg.pc + 12'd1;
                        if_next = ib_reg; regs_next.pc = word_reg + 12'd1;
                    end
                    default:
                    begin
                        if_next = ib_reg; regs_next.pc = word_reg;
                    end
                endcase
            end
            S_OWAIT:
            begin
                state_next = S_DONE;
                if (item_reg.op == tbmc_pkg::OP_EXAMINE)
                    res_next.memory_word = rdv;
                else
                begin
                    regs_next.pc = regs_reg.pc + 12'd1;
                    case (fn)
                        tbmc_pkg::FN_AND: regs_next.acc = regs_reg.acc & rdv;
                        tbmc_pkg::FN_TAD:
                        begin
                            regs_next.acc = sum[11:0];
                            regs_next.link = regs_reg.link ^ sum[12];
                        end
                        default:
                        begin
                            mem_a15 = ea_reg; mem_we = 1'b1; mem_wd = isz_v;
                            if (isz_v == '0) regs_next.pc = regs_reg.pc + 12'd2;
                        end
                    endcase
                end
            end
            S_DONE:
            begin
                res_next.program_counter = regs_reg.pc;
                res_next.accumulator = regs_reg.acc;
                res_next.link = regs_reg.link;
                res_next.halted = regs_reg.halt;
                res_next.effective_address = ea_reg;
                res_next.instruction_field = if_reg;
                res_next.operand_field = df_reg;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            regs_reg <= '0;
            df_reg <= '0; if_reg <= '0; ib_reg <= '0;
            sw_reg <= '0;
            out_valid_reg <= 1'b0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            regs_reg <= regs_next;
            df_reg <= df_next; if_reg <= if_next; ib_reg <= ib_next;
            if (cfg_we)
                sw_reg <= cfg_wdata;
            out_valid_reg <= out_valid_next;
            rd_ok_reg <= mem_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        ea_reg <= ea_next;
        word_reg <= word_next;
        res_reg <= res_next;
    end
endmodule

FILE: rtl/core/tbmc_checker.sv
// port-level checks for the execute core, bound to the top level
module tbmc_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input tbmc_pkg::out_item_t out_payload
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_payload))
        else $error("result dropped or changed under stall");
    a_no_accept_after: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item accepted while one is in work");
    a_io_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_payload.io_request |-> out_payload.io_device == '0
        && out_payload.io_command == '0)
        else $error("device fields set without a request");
endmodule

bind twelve_bit_minicomputer_execute_core tbmc_checker u_tbmc_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_payload(out_ch.payload)
);
